[src/i2p_pkg.sv]
// shared types, character codes and priority function for the infix to postfix converter
package i2p_pkg;

   // character codes
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   // operator priorities
   localparam logic [1:0] PRIO_NONE = 2'd0;
   localparam logic [1:0] PRIO_ADD  = 2'd1;
   localparam logic [1:0] PRIO_MUL  = 2'd2;
   localparam logic [1:0] PRIO_POW  = 2'd3;

   // queue depths between front, back and result side
   localparam int ITEM_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH  = 4;

   typedef enum logic [2:0] {
      KIND_ALNUM,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_OPER,
      KIND_END
   } kind_type;

   // classified item from front to back
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  symbol;
      logic [1:0]  prio;
   } item_type;

   // one postfix character on the result side
   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
   } rsp_type;

   function automatic logic [1:0] i2p_prio(input logic [7:0] c);
      logic [1:0] p;
      p = PRIO_NONE;
      if (c == CHAR_PLUS || c == CHAR_MINUS) p = PRIO_ADD;
      if (c == CHAR_STAR || c == CHAR_SLASH) p = PRIO_MUL;
      if (c == CHAR_CARET) p = PRIO_POW;
      return p;
   endfunction

   function automatic logic i2p_is_alnum(input logic [7:0] c);
      return (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
   endfunction

endpackage

[src/i2p_fifo.sv]
// small register-based first-in first-out queue
module i2p_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/i2p_front.sv]
// front end: classifies incoming characters and queues them for the back end
module i2p_front
   import i2p_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_expression,
   output logic       req_full,
   input  logic       item_pop,
   output item_type   item_data,
   output logic       item_empty
);

   item_type item_new;

   // classify the character
   always_comb begin
      item_new.symbol = req_symbol;
      item_new.prio   = i2p_prio(req_symbol);
      if (req_end_of_expression) begin
         item_new.kind = KIND_END;
      end else if (i2p_is_alnum(req_symbol)) begin
         item_new.kind = KIND_ALNUM;
      end else if (req_symbol == CHAR_LPAREN) begin
         item_new.kind = KIND_LPAREN;
      end else if (req_symbol == CHAR_RPAREN) begin
         item_new.kind = KIND_RPAREN;
      end else begin
         item_new.kind = KIND_OPER;
      end
   end

   // queue toward the back end
   i2p_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (ITEM_QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (item_new),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item_data),
      .empty     (item_empty)
   );

endmodule

[src/i2p_back.sv]
// back end: operator stack and sequencer that emits postfix characters
module i2p_back
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     item_empty,
   input  item_type item_data,
   output logic     item_pop,
   input  logic     out_full,
   output logic     out_push,
   output rsp_type  out_data
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      ST_FETCH,
      ST_WORK
   } state_type;

   state_type   state_ff, state_in;
   item_type    item_ff, item_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_char_ff, pend_char_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // stack memory with registered top-of-stack read
   logic [7:0]        stack_mem [STACK_DEPTH];
   logic [7:0]        top_ff;
   logic              stk_we;
   logic [ADDR_W-1:0] stk_waddr;
   logic [ADDR_W-1:0] stk_raddr;
   logic [CNT_W-1:0]  raddr_full;

   logic stk_nonempty;
   logic stk_has_room;
   logic pop_cond;

   assign stk_nonempty = (count_ff != '0);
   assign stk_has_room = (count_ff < CNT_W'(STACK_DEPTH));
   assign stk_waddr    = count_ff[ADDR_W-1:0];
   assign raddr_full   = count_in - CNT_W'(1);
   assign stk_raddr    = raddr_full[ADDR_W-1:0];

   // loop condition for close paren and operators
   always_comb begin
      if (item_ff.kind == KIND_RPAREN) begin
         pop_cond = stk_nonempty && (top_ff != CHAR_LPAREN);
      end else begin
         pop_cond = stk_nonempty && (i2p_prio(top_ff) >= item_ff.prio);
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      count_in      = count_ff;
      stk_we        = 1'b0;
      item_pop      = 1'b0;
      out_push      = 1'b0;
      out_data      = '{out_char: item_ff.symbol, last_of_run: 1'b1};
      case (state_ff)
         ST_FETCH: begin
            if (!item_empty) begin
               item_pop = 1'b1;
               item_in  = item_data;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            case (item_ff.kind)
               KIND_ALNUM: begin
                  if (!out_full) begin
                     out_push = 1'b1;
                     state_in = ST_FETCH;
                  end
               end
               KIND_LPAREN: begin
                  if (stk_has_room) begin
                     stk_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_FETCH;
               end
               KIND_END: begin
                  if (!out_full) begin
                     out_push = 1'b1;
                     if (stk_nonempty) begin
                        out_data = '{out_char: top_ff, last_of_run: 1'b0};
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        out_data = '{out_char: CHAR_NEWLINE, last_of_run: 1'b1};
                        state_in = ST_FETCH;
                     end
                  end
               end
               KIND_RPAREN, KIND_OPER: begin
                  // a popped character is held in a pending register so its last flag is known
                  if (!pend_valid_ff || !out_full) begin
                     out_push = pend_valid_ff;
                     out_data = '{out_char: pend_char_ff, last_of_run: !pop_cond};
                     if (pop_cond) begin
                        pend_char_in  = top_ff;
                        pend_valid_in = 1'b1;
                        count_in      = count_ff - CNT_W'(1);
                     end else begin
                        pend_valid_in = 1'b0;
                        state_in      = ST_FETCH;
                        if (item_ff.kind == KIND_RPAREN) begin
                           if (stk_nonempty) begin
                              count_in = count_ff - CNT_W'(1);
                           end
                        end else if (stk_has_room) begin
                           stk_we   = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
               end
               default: begin
                  state_in = ST_FETCH;
               end
            endcase
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FETCH;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
      end
      item_ff      <= item_in;
      pend_char_ff <= pend_char_in;
   end

   // stack write and top read, a push forwards its own data
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= item_ff.symbol;
         top_ff               <= item_ff.symbol;
      end else begin
         top_ff <= stack_mem[stk_raddr];
      end
   end

endmodule

[src/infix_to_postfix_converter_top.sv]
// Infix to postfix converter: front classifier, operator stack engine, result queue.
// The stack sequencer fetches an item and then works on it, and takes no new character
// until it is done with the last; it pops operators off the stack one at a time and
// waits while the result queue is full.
// Reset clears the stack count and both queues; stack contents are not cleared.
module infix_to_postfix_converter_top
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_symbol,
   input  logic       req_end_of_expression,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run
);

   item_type item_data;
   logic     item_empty;
   logic     item_pop;
   logic     out_full;
   logic     out_push;
   rsp_type  out_data;
   rsp_type  rsp_data;

   // front end
   i2p_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_symbol            (req_symbol),
      .req_end_of_expression (req_end_of_expression),
      .req_full              (full),
      .item_pop              (item_pop),
      .item_data             (item_data),
      .item_empty            (item_empty)
   );

   // stack engine
   i2p_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_empty (item_empty),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   // result queue
   i2p_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

   assign rsp_out_char    = rsp_data.out_char;
   assign rsp_last_of_run = rsp_data.last_of_run;

endmodule
